// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tcpq_pkg.sv =====
`default_nettype none
package tcpq_pkg;

  // Operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_DEPART = 3'd2;
  localparam logic [2:0] OP_DELAY  = 3'd3;
  localparam logic [2:0] OP_RETAG  = 3'd4;
  localparam logic [2:0] OP_EXISTS = 3'd5;

  localparam int ID_W  = 10;
  localparam int TAG_W = 24;

  // Queue size; counts and positions are sized from it
  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W = $clog2(QUEUE_DEPTH);

  // One stored entry; mk flags a tag match for the delay reorder
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             urg;
    logic             mk;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // What every cell does this cycle
  typedef enum logic [2:0] {M_HOLD, M_ROTATE, M_OPEN, M_CLOSE, M_SORT} cell_mode_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    cell_mode_t       mode;
    logic [POS_W-1:0] pos;      // gap position for open and close
    logic [CNT_W-1:0] occ;      // entries in use, bounds the sort
    logic             odd;      // odd sort phase pairs (1,2), (3,4), ...
    entry_t           ent;      // entry written at pos on open
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/tcpq_cell.sv =====
`default_nettype none
// One slot of the chain: rotates toward the head, opens or closes a gap,
// or swaps with a neighbor during the delay sort
module tcpq_cell
  import tcpq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [POS_W-1:0] idx,
  input  wire cell_ctl_t        ctl,
  input  wire entry_t           up,     // neighbor toward the tail
  input  wire entry_t           down,   // neighbor toward the head
  output entry_t                held
);

  entry_t     slot;
  logic [1:0] key_self, key_up, key_down;
  logic       left_side, swap_up, swap_down;

  // Sort key: urgent before normal, unmarked before marked
  assign key_self = {~slot.urg, slot.mk};
  assign key_up   = {~up.urg, up.mk};
  assign key_down = {~down.urg, down.mk};

  // Odd-even pairing; only pairs fully inside the occupied range swap
  assign left_side = (idx[0] == ctl.odd);
  assign swap_up   = left_side && ((CNT_W'(idx) + CNT_W'(1)) < ctl.occ) &&
                     (key_self > key_up);
  assign swap_down = !left_side && (idx != '0) && (CNT_W'(idx) < ctl.occ) &&
                     (key_down > key_self);

  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      M_HOLD: ;
      M_ROTATE: slot <= up;
      M_OPEN: begin
        if (idx == ctl.pos) begin
          slot <= ctl.ent;
        end else if (idx > ctl.pos) begin
          slot <= down;
        end
      end
      M_CLOSE: begin
        if (idx >= ctl.pos) begin
          slot <= up;
        end
      end
      M_SORT: begin
        if (swap_up) begin
          slot <= up;
        end else if (swap_down) begin
          slot <= down;
        end
      end
      default: ;
    endcase
  end

  assign held = slot;

endmodule
`default_nettype wire

// ===== hdl/two_class_keyed_priority_queue_unit.sv =====
`default_nettype none
// channel | handshake            | payload
// in      | in_valid, in_stall   | kind entry_id entry_class urgent tag_code new_tag_code
// out     | out_valid, out_stall | status found popped_id entry_count urgent_count
// cfg     | cfg_we               | cfg_data (queue class)
// An item is walked while the chain rotates once (search, retag, tag marks), then
// the apply state opens or closes a gap; delay adds odd-even swap steps in the sort
// state. The result is loaded into the output register from the done state, and
// the next input is taken once the unit is back in idle.
// rst (synchronous) empties the queue; cells above the count are never read.
// A stalled result sits in the output register; the next item runs meanwhile and
// waits in its last cycle only while that earlier result is still stalled.
module two_class_keyed_priority_queue_unit
  import tcpq_pkg::*;
#(
  parameter int MAX_ENTRY_ID = 1023
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [9:0]  entry_id,
  input  wire logic        entry_class,
  input  wire logic        urgent,
  input  wire logic [23:0] tag_code,
  input  wire logic [23:0] new_tag_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic             found,
  output logic [9:0]       popped_id,
  output logic [6:0]       entry_count,
  output logic [6:0]       urgent_count
);
  `include "assert_macros.svh"

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_APPLY, S_SORT, S_DONE} st_t;
  st_t st;

  logic             qtype;
  logic [CNT_W-1:0] occ, urgc;
  logic [CNT_W-1:0] occ_next, urgc_next;
  // Latched command
  logic [2:0]       op;
  logic [ID_W-1:0]  oid;
  logic             ourg, ocls;
  logic [TAG_W-1:0] otag, ontag;
  // Walk state
  logic [POS_W-1:0] step;
  logic             hit;
  logic [POS_W-1:0] hpos;
  logic             hurg;
  // Result waiting for the output register
  logic             res_status, res_found;
  logic [ID_W-1:0]  res_pop;

  // Chain: head is cell 0, cell k reads cell k+1, tail reads feed
  entry_t    cells [QUEUE_DEPTH];
  entry_t    feed, head;
  cell_ctl_t ctl;

  logic in_range, id_ok, id_here, head_match;
  logic ins_ok, rem_ok, dep_ok, op_fail;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_t up_ent, down_ent;
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign up_ent = feed;
      end else begin : g_mid
        assign up_ent = cells[g+1];
      end
      if (g == 0) begin : g_head
        assign down_ent = ctl.ent;
      end else begin : g_body
        assign down_ent = cells[g-1];
      end
      tcpq_cell u_cell (
        .clk(clk), .idx(POS_W'(g)), .ctl(ctl), .up(up_ent), .down(down_ent),
        .held(cells[g])
      );
    end
  endgenerate

  // During the walk the head holds the entry at position step
  assign head       = cells[0];
  assign in_range   = (CNT_W'(step) < occ);
  assign id_ok      = (oid != '0) && (int'(oid) <= MAX_ENTRY_ID);
  assign id_here    = in_range && (head.id == oid);
  assign head_match = (head.tag == otag);

  // Outcome of the walk
  assign ins_ok = (op == OP_INSERT) && id_ok && (ocls == qtype) &&
                  (occ < CNT_W'(QUEUE_DEPTH)) && !hit;
  assign rem_ok = (op == OP_REMOVE) && id_ok && hit;
  assign dep_ok = (op == OP_DEPART) && (occ != '0);

  always_comb begin
    op_fail = 1'b1;
    unique case (op)
      OP_INSERT: op_fail = !ins_ok;
      OP_REMOVE: op_fail = !rem_ok;
      OP_DEPART: op_fail = !dep_ok;
      OP_DELAY, OP_RETAG, OP_EXISTS: op_fail = 1'b0;
      default: op_fail = 1'b1;
    endcase
  end

  // Counts after the operation
  always_comb begin
    occ_next = occ;
    urgc_next = urgc;
    if (ins_ok) begin
      occ_next = occ + CNT_W'(1);
      urgc_next = urgc + CNT_W'(ourg);
    end else if (rem_ok) begin
      occ_next = occ - CNT_W'(1);
      urgc_next = urgc - CNT_W'(hurg);
    end else if (dep_ok) begin
      occ_next = occ - CNT_W'(1);
      urgc_next = urgc - CNT_W'(head.urg);
    end
  end

  // Cell command and tail feed
  always_comb begin
    ctl = '0;
    ctl.occ = occ;
    ctl.odd = step[0];
    ctl.ent.id = oid;
    ctl.ent.urg = ourg;
    ctl.ent.tag = otag;
    feed = head;
    unique case (st)
      S_WALK: begin
        ctl.mode = M_ROTATE;
        if (in_range) begin
          feed.mk = head_match;
          if (op == OP_RETAG && head_match) feed.tag = ontag;
        end
      end
      S_APPLY: begin
        if (ins_ok) begin
          // urgent entries go after the last urgent one, normal ones at the tail
          ctl.mode = M_OPEN;
          ctl.pos = ourg ? POS_W'(urgc) : POS_W'(occ);
        end else if (rem_ok) begin
          ctl.mode = M_CLOSE;
          ctl.pos = hpos;
        end else if (dep_ok) begin
          ctl.mode = M_CLOSE;
        end
      end
      S_SORT: ctl.mode = M_SORT;
      default: ;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      qtype <= 1'b0;
      occ <= '0;
      urgc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) qtype <= cfg_data;
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            op <= kind; oid <= entry_id; ocls <= entry_class; ourg <= urgent;
            otag <= tag_code; ontag <= new_tag_code;
            step <= '0; hit <= 1'b0;
            st <= S_WALK;
          end
        end
        S_WALK: begin
          if (id_here && !hit) begin
            hit <= 1'b1; hpos <= step; hurg <= head.urg;
          end
          step <= step + POS_W'(1);
          if (step == POS_W'(QUEUE_DEPTH - 1)) st <= S_APPLY;
        end
        S_APPLY: begin
          occ <= occ_next;
          urgc <= urgc_next;
          res_status <= op_fail;
          res_found <= (op == OP_EXISTS) && id_ok && hit;
          res_pop <= dep_ok ? head.id : '0;
          st <= (op == OP_DELAY) ? S_SORT : S_DONE;
        end
        S_SORT: begin
          step <= step + POS_W'(1);
          if (step == POS_W'(QUEUE_DEPTH - 1)) st <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
      if (st == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        status <= res_status;
        found <= res_found;
        popped_id <= res_pop;
        entry_count <= occ;
        urgent_count <= urgc;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (st != S_IDLE);

  `CHK_ALWAYS(a_occ_max, clk, rst, occ <= CNT_W'(QUEUE_DEPTH), "occupancy overflow")
  `CHK_ALWAYS(a_urg_le_occ, clk, rst, urgc <= occ, "urgent count above occupancy")
  `CHK_ALWAYS(a_busy_stall, clk, rst, (st == S_IDLE) || in_stall, "input open while busy")
  `CHK_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status), "result lost")

endmodule
`default_nettype wire

// ===== tb/sv/two_class_keyed_priority_queue_unit_tb.sv =====
module two_class_keyed_priority_queue_unit_tb;
  import tcpq_pkg::*;

  localparam int DEPTH = 64;
  localparam int MAX_ID = 1023;
  localparam int OP_CYCLES = 2 * DEPTH + 8;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  entry_id;
    logic        entry_class;
    logic        urgent;
    logic [23:0] tag_code;
    logic [23:0] new_tag_code;
  } op_t;

  typedef struct packed {
    logic       status;
    logic       found;
    logic [9:0] popped_id;
    logic [6:0] entry_count;
    logic [6:0] urgent_count;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic [9:0] entry_id = '0;
  logic entry_class = 1'b0;
  logic urgent = 1'b0;
  logic [23:0] tag_code = '0;
  logic [23:0] new_tag_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status, found;
  logic [9:0] popped_id;
  logic [6:0] entry_count, urgent_count;

  two_class_keyed_priority_queue_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .entry_id(entry_id),
    .entry_class(entry_class), .urgent(urgent), .tag_code(tag_code),
    .new_tag_code(new_tag_code), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found(found), .popped_id(popped_id),
    .entry_count(entry_count), .urgent_count(urgent_count)
  );

  always #5 clk = ~clk;

  // Predictor state: the queue as an ordered list of entries
  entry_t queue_model[$];
  logic   class_model = 1'b0;
  int     urgent_model = 0;

  op_t    pending_ops[$];
  reply_t expected_replies[$];
  int     errors = 0;
  longint cycle = 0;
  bit     quiet = 1'b0;     // no random idling or output stalls while set
  bit     feed_done = 1'b0;
  int     results_seen = 0;
  int     ops_sent = 0;

  function automatic int locate(logic [9:0] id);
    for (int i = 0; i < queue_model.size(); i++)
      if (queue_model[i].id == id) return i;
    return -1;
  endfunction

  function automatic reply_t apply_op(op_t op);
    reply_t r;
    entry_t e;
    entry_t reordered[$];
    int pos;
    bit ok_id;
    r = '0;
    r.status = 1'b1;
    ok_id = op.entry_id >= 1 && op.entry_id <= MAX_ID;
    case (op.kind)
      OP_INSERT: begin
        if (ok_id && op.entry_class == class_model && queue_model.size() < DEPTH
            && locate(op.entry_id) < 0) begin
          e.id = op.entry_id;
          e.urg = op.urgent;
          e.tag = op.tag_code;
          if (op.urgent) begin
            queue_model.insert(urgent_model, e);
            urgent_model++;
          end else begin
            queue_model.push_back(e);
          end
          r.status = 1'b0;
        end
      end
      OP_REMOVE: begin
        pos = ok_id ? locate(op.entry_id) : -1;
        if (pos >= 0) begin
          if (queue_model[pos].urg) urgent_model--;
          queue_model.delete(pos);
          r.status = 1'b0;
        end
      end
      OP_DEPART: begin
        if (queue_model.size() > 0) begin
          r.popped_id = queue_model[0].id;
          if (queue_model[0].urg) urgent_model--;
          queue_model.delete(0);
          r.status = 1'b0;
        end
      end
      OP_DELAY: begin
        // stable partition: urgent unmatched, urgent matched, normal ditto
        for (int u = 1; u >= 0; u--)
          for (int m = 0; m < 2; m++)
            foreach (queue_model[i])
              if (queue_model[i].urg == u[0] && (queue_model[i].tag == op.tag_code) == m[0])
                reordered.push_back(queue_model[i]);
        queue_model = reordered;
        r.status = 1'b0;
      end
      OP_RETAG: begin
        foreach (queue_model[i])
          if (queue_model[i].tag == op.tag_code) queue_model[i].tag = op.new_tag_code;
        r.status = 1'b0;
      end
      OP_EXISTS: begin
        r.found = ok_id && locate(op.entry_id) >= 0;
        r.status = 1'b0;
      end
      default: ;
    endcase
    r.entry_count = 7'(queue_model.size());
    r.urgent_count = 7'(urgent_model);
    return r;
  endfunction

  // Small tag pool so delay and retag hit often
  function automatic logic [23:0] pick_tag();
    case ($urandom_range(0, 5))
      0: return 24'h4A464B;
      1: return 24'h4C4158;
      2: return 24'h434447;
      3: return 24'hFFFFFF;
      4: return 24'h000000;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic op_t make_op(logic [2:0] k, logic [9:0] id, logic cls, logic urg,
                                  logic [23:0] t, logic [23:0] nt);
    op_t op;
    op.kind = k;
    op.entry_id = id;
    op.entry_class = cls;
    op.urgent = urg;
    op.tag_code = t;
    op.new_tag_code = nt;
    return op;
  endfunction

  function automatic op_t random_op();
    int sel;
    logic [9:0] id;
    sel = $urandom_range(0, 99);
    if (sel < 90) id = 10'($urandom_range(1, 40));
    else if (sel < 95) id = 10'($urandom());
    else id = (sel < 97) ? 10'd0 : 10'd1023;
    sel = $urandom_range(0, 99);
    if (sel < 40)
      return make_op(OP_INSERT, id, ($urandom_range(0, 9) == 0) ? ~class_model : class_model,
                     1'($urandom()), pick_tag(), 24'($urandom()));
    if (sel < 52) return make_op(OP_REMOVE, id, 1'($urandom()), 1'($urandom()), pick_tag(),
                                 24'($urandom()));
    if (sel < 66) return make_op(OP_DEPART, id, 1'($urandom()), 1'($urandom()), pick_tag(),
                                 24'($urandom()));
    if (sel < 75) return make_op(OP_DELAY, id, 1'($urandom()), 1'($urandom()), pick_tag(),
                                 24'($urandom()));
    if (sel < 84) return make_op(OP_RETAG, id, 1'($urandom()), 1'($urandom()), pick_tag(),
                                 pick_tag());
    if (sel < 97) return make_op(OP_EXISTS, id, 1'($urandom()), 1'($urandom()), pick_tag(),
                                 24'($urandom()));
    return make_op(3'($urandom_range(6, 7)), id, 1'($urandom()), 1'($urandom()),
                   24'($urandom()), 24'($urandom()));
  endfunction

  // Driver: presents queued operations; predicts on each transfer
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(apply_op({kind, entry_id, entry_class, urgent,
                                             tag_code, new_tag_code}));
        ops_sent <= ops_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
          op_t op;
          op = pending_ops.pop_front();
          in_valid <= 1'b1;
          {kind, entry_id, entry_class, urgent, tag_code, new_tag_code} <= op;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !quiet && $urandom_range(0, 99) < 15;
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("result transfer with nothing expected");
        errors <= errors + 1;
      end else begin
        reply_t e;
        e = expected_replies.pop_front();
        results_seen <= results_seen + 1;
        if (status !== e.status) begin
          $error("status expected %0d got %0d", e.status, status); errors <= errors + 1;
        end
        if (found !== e.found) begin
          $error("found expected %0d got %0d", e.found, found); errors <= errors + 1;
        end
        if (popped_id !== e.popped_id) begin
          $error("popped_id expected %0d got %0d", e.popped_id, popped_id);
          errors <= errors + 1;
        end
        if (entry_count !== e.entry_count) begin
          $error("entry_count expected %0d got %0d", e.entry_count, entry_count);
          errors <= errors + 1;
        end
        if (urgent_count !== e.urgent_count) begin
          $error("urgent_count expected %0d got %0d", e.urgent_count, urgent_count);
          errors <= errors + 1;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycle > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Wait for all operations to transfer and every result to arrive
  task automatic drain();
    while (pending_ops.size() > 0 || in_valid) @(posedge clk);
    while (expected_replies.size() > 0) @(posedge clk);
    repeat (OP_CYCLES) @(posedge clk);
  endtask

  task automatic set_class(logic c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    class_model = c;
  endtask

  initial begin
    logic [23:0] t;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_class(1'b0);

    // Directed: edges of ids, every kind, urgent ordering, empty depart
    pending_ops.push_back(make_op(OP_DEPART, 10'd0, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_INSERT, 10'd0, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_INSERT, 10'd1023, 1'b0, 1'b0, 24'hFFFFFF, 24'hFFFFFF));
    pending_ops.push_back(make_op(OP_INSERT, 10'd1, 1'b0, 1'b1, 24'h414141, 24'h0));
    pending_ops.push_back(make_op(OP_INSERT, 10'd2, 1'b0, 1'b0, 24'h414141, 24'h0));
    pending_ops.push_back(make_op(OP_INSERT, 10'd3, 1'b0, 1'b1, 24'h424242, 24'h0));
    pending_ops.push_back(make_op(OP_INSERT, 10'd2, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_INSERT, 10'd4, 1'b1, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_EXISTS, 10'd3, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_EXISTS, 10'd0, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_EXISTS, 10'd77, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_DELAY, 10'd0, 1'b0, 1'b0, 24'h414141, 24'h0));
    pending_ops.push_back(make_op(OP_DELAY, 10'd0, 1'b0, 1'b0, 24'h123456, 24'h0));
    pending_ops.push_back(make_op(OP_RETAG, 10'd0, 1'b0, 1'b0, 24'h414141, 24'h424242));
    pending_ops.push_back(make_op(OP_REMOVE, 10'd0, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_REMOVE, 10'd99, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_REMOVE, 10'd3, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(3'd6, 10'd1, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(3'd7, 10'd1, 1'b1, 1'b1, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_DEPART, 10'd0, 1'b0, 1'b0, 24'h0, 24'h0));
    pending_ops.push_back(make_op(OP_DEPART, 10'd0, 1'b0, 1'b0, 24'h0, 24'h0));
    drain();

    // Fill to capacity, overflow, delay on the full queue, then empty; all with no idling
    quiet = 1'b1;
    for (int i = 1; i <= DEPTH + 2; i++)
      pending_ops.push_back(make_op(OP_INSERT, 10'(i + 500), 1'b0, 1'(i % 3 == 0),
                                    (i % 2) ? 24'h4A464B : 24'h4C4158, 24'h0));
    pending_ops.push_back(make_op(OP_DELAY, 10'd0, 1'b0, 1'b0, 24'h4A464B, 24'h0));
    for (int i = 0; i < DEPTH + 1; i++)
      pending_ops.push_back(make_op(OP_DEPART, 10'd0, 1'b0, 1'b0, 24'h0, 24'h0));
    drain();
    quiet = 1'b0;

    // Random phases across both class settings
    for (int phase = 0; phase < 4; phase++) begin
      set_class(phase[0]);
      for (int n = 0; n < 500; n++) begin
        if (n == 250) begin
          while (pending_ops.size() > 0 || in_valid) @(posedge clk);
          while (expected_replies.size() > 0) @(posedge clk);
        end
        quiet = (phase == 2 && n >= 100 && n < 300);
        pending_ops.push_back(random_op());
        // wait until no more than four operations are pending
        while (pending_ops.size() > 4) @(posedge clk);
      end
      quiet = 1'b0;
      drain();
    end

    $display("Covered %0d operations and %0d checked results over both queue classes,",
             ops_sent, results_seen);
    $display("including full-queue overflow, empty departs, delays and retags.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
